// ===== src/dtrc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtrc_pkg
// Shared types and codes for the transmit ring chunker.
// ----------------------------------------------------------------------------
package dtrc_pkg;

    localparam logic [1:0] CMD_PUT  = 2'd0;
    localparam logic [1:0] CMD_DONE = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] OP_NOP  = 2'd0;
    localparam logic [1:0] OP_PUT  = 2'd1;
    localparam logic [1:0] OP_DONE = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] index;
    } op_t;

    typedef struct packed {
        logic       busy_res;
        logic [7:0] read_data;
        logic [7:0] launch_len;
        logic [7:0] launch_start;
        logic       launch;
        logic       accepted;
    } res_t;

    localparam int RES_W  = $bits(res_t);
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

// ===== src/dtrc_ram.sv =====
// ----------------------------------------------------------------------------
// dtrc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dtrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dtrc_front.sv =====
// ----------------------------------------------------------------------------
// dtrc_front
// Accept input beats, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module dtrc_front
    import dtrc_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_cmd,
    input  logic [7:0] in_byte,
    input  logic [7:0] in_index,
    output logic       q_valid,
    output op_t        q_op,
    input  logic       q_pop
);

    op_t        entry_reg [2];
    op_t        new_op;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;

    always_comb
    begin
        new_op.data  = in_byte;
        new_op.index = in_index;
        case (in_cmd)
            CMD_PUT:  new_op.kind = OP_PUT;
            CMD_DONE: new_op.kind = OP_DONE;
            CMD_READ: new_op.kind = (32'(in_index) < RING_DEPTH) ? OP_READ : OP_NOP;
            default:  new_op.kind = OP_NOP;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_op     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(q_pop && q_valid))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop && q_valid)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/dtrc_back.sv =====
// ----------------------------------------------------------------------------
// dtrc_back
// Execute queued operations against the ring indices and the byte store.
// ----------------------------------------------------------------------------
module dtrc_back
    import dtrc_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  op_t        q_op,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output res_t       out_res
);

    localparam int IW = $clog2(RING_DEPTH);
    localparam logic [IW:0]   DEPTH_V = (IW + 1)'(RING_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic          state_reg;
    logic          state_next;
    logic [IW-1:0] head_reg;
    logic [IW-1:0] head_next;
    logic [IW-1:0] tail_reg;
    logic [IW-1:0] tail_next;
    logic [IW-1:0] nhead_reg;
    logic [IW-1:0] nhead_next;
    logic          busy_reg;
    logic          busy_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    res_t          res_reg;
    res_t          res_next;

    logic          issue;
    logic [IW-1:0] tail_bump;
    logic [IW-1:0] lh;
    logic [IW-1:0] lt;
    logic [IW:0]   len;
    logic [IW-1:0] lnh;
    logic          ram_we;
    logic [7:0]    ram_rdata;

    assign issue     = (state_reg == ST_IDLE) && q_valid && (!out_valid_reg || out_ready);
    assign q_pop     = issue;
    assign tail_bump = (tail_reg == LAST_IDX) ? '0 : tail_reg + IW'(1);
    assign ram_we    = issue && (q_op.kind == OP_PUT) && (tail_bump != head_reg);

    dtrc_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (q_op.data),
        .raddr (IW'(q_op.index)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (q_op.kind == OP_PUT)
        begin
            lh = head_reg;
            lt = tail_bump;
        end
        else
        begin
            lh = nhead_reg;
            lt = tail_reg;
        end
        if (lh < lt)
        begin
            len = {1'b0, lt} - {1'b0, lh};
            lnh = lt;
        end
        else
        begin
            len = DEPTH_V - {1'b0, lh};
            lnh = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        nhead_next     = nhead_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;

        if (issue)
        begin
            res_next = '0;
            case (q_op.kind)
                OP_PUT:
                begin
                    if (tail_bump != head_reg)
                    begin
                        tail_next         = tail_bump;
                        res_next.accepted = 1'b1;
                        if (!busy_reg)
                        begin
                            busy_next             = 1'b1;
                            nhead_next            = lnh;
                            res_next.launch       = 1'b1;
                            res_next.launch_start = 8'(lh);
                            res_next.launch_len   = 8'(len);
                        end
                    end
                end
                OP_DONE:
                begin
                    if (busy_reg)
                    begin
                        head_next = nhead_reg;
                        busy_next = 1'b0;
                        if (nhead_reg != tail_reg)
                        begin
                            busy_next             = 1'b1;
                            nhead_next            = lnh;
                            res_next.launch       = 1'b1;
                            res_next.launch_start = 8'(lh);
                            res_next.launch_len   = 8'(len);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            res_next.busy_res = busy_next;
            if (q_op.kind == OP_READ)
            begin
                state_next = ST_READ;
            end
            else
            begin
                out_valid_next = 1'b1;
            end
        end
        else if (state_reg == ST_READ)
        begin
            res_next.read_data = ram_rdata;
            res_next.busy_res  = busy_reg;
            out_valid_next     = 1'b1;
            state_next         = ST_IDLE;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            nhead_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            nhead_reg     <= nhead_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== src/dma_tx_ring_chunker.sv =====
// ----------------------------------------------------------------------------
// dma_tx_ring_chunker
// Transmit byte ring that hands a DMA engine contiguous chunks.
// ----------------------------------------------------------------------------
// Each input beat is a put, a transfer done or a read, and yields exactly one
// result beat. The ring holds RING_DEPTH-1 bytes; a put on an idle ring
// launches a chunk that runs to the tail or to the end of the buffer. Put,
// done and unused commands finish as they issue in the execution stage; a
// read waits in a read state for the registered read port of the byte store.
// A two-entry queue sits between the input stage and the execution stage, and
// the result register frees in the cycle it is taken. The store needs no
// clearing pass; reading a slot never written returns an undefined byte.
// ----------------------------------------------------------------------------
module dma_tx_ring_chunker
    import dtrc_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,  // byte_in, read_index
    input  logic [1:0]         s_axis_tuser,  // cmd
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // accepted, launch, launch_start, launch_len, read_data, busy_res
    output logic [TDATA_W-1:0] m_axis_tdata
);

    logic q_valid;
    op_t  q_op;
    logic q_pop;
    res_t out_res;

    dtrc_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tuser),
        .in_byte  (s_axis_tdata[7:0]),
        .in_index (s_axis_tdata[15:8]),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .q_pop    (q_pop)
    );

    dtrc_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = TDATA_W'(out_res);

endmodule
